// ----- rtl/core/usb_transfer_descriptor_chain_builder_assert.svh -----
// Assertion macros for the descriptor chain builder.
// Each macro expects clk and rst in scope at the point of use.
`ifndef USB_TRANSFER_DESCRIPTOR_CHAIN_BUILDER_ASSERT_SVH
`define USB_TRANSFER_DESCRIPTOR_CHAIN_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define UTD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define UTD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define UTD_ASSERT_IMP(name, ante, cons)
`define UTD_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ----- rtl/core/usbtd_pkg.sv -----
package usbtd_pkg;

  localparam int unsigned POOL_SLOTS = 512;
  localparam int unsigned MAX_PIECES = 64;
  localparam int unsigned SLOT_W     = 9;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned LEN_W      = 15;
  localparam int unsigned MP_W       = 7;
  localparam int unsigned END_W      = 11;

  localparam logic [LEN_W-1:0] LEN_LIMIT  = 15'd16384;
  localparam logic [31:0]      ST_FULL    = 32'h0080_0000;
  localparam logic [31:0]      ST_LOW     = 32'h0480_0000;
  localparam logic [31:0]      LINK_DEPTH = 32'h0000_0004;
  localparam logic [31:0]      LINK_END   = 32'h0000_0001;
  localparam logic [MP_W-1:0]  MP_MAX     = 7'd64;
  localparam logic [MP_W-1:0]  MP_RESET   = 7'd64;

  typedef enum logic {
    REG_POOL_BASE  = 1'b0,
    REG_MAX_PACKET = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_OUT   = 2'd0,
    KIND_IN    = 2'd1,
    KIND_SETUP = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  localparam logic [7:0] PID_OUT   = 8'hE1;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_SETUP = 8'h2D;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;        // latch request fields
    logic count_step;  // take one packet out of the length
    logic emit_init;   // rewind for descriptor output
    logic emit_step;   // output one descriptor and advance
    logic emit_err;    // output the reject result
  } dp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic early_bad;   // bad kind, length or low-speed bulk
    logic rem_gt_mp;   // more than one packet left
    logic cnt_full;    // piece count at its limit
    logic slot_bad;    // chain runs past the pool
    logic last;        // current descriptor is the final one
  } dp_stat_t;

  function automatic logic [7:0] pid_of(input logic [1:0] kind);
    logic [7:0] pid;
    case (kind)
      KIND_OUT:   pid = PID_OUT;
      KIND_IN:    pid = PID_IN;
      KIND_SETUP: pid = PID_SETUP;
      default:    pid = 8'h00;
    endcase
    return pid;
  endfunction

endpackage

// ----- rtl/core/usb_transfer_descriptor_chain_builder.sv -----
// Flow: a request of P descriptors is first sized in the count state, one packet size taken
//   off per cycle, then the check state tests the pool bounds, then descriptors go out back to back.
// Busy holds from start until the request is done (P up to 64), so no new request is taken
//   before then; a reject result is issued from the count or the check state.
// Results show for exactly one cycle on strobe; the receiver cannot stall.
// Reset (rst, synchronous): sequencer idle, strobe low, pool_base 0, max_packet 64.
`include "usb_transfer_descriptor_chain_builder_assert.svh"

module usb_transfer_descriptor_chain_builder
  import usbtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // register write port
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [31:0]       wr_data,
  // request
  input  logic              start,
  output logic              busy,
  input  logic [6:0]        usb_address,
  input  logic [3:0]        endpoint,
  input  logic [1:0]        packet_kind,
  input  logic              start_toggle,
  input  logic [31:0]       buffer_address,
  input  logic [LEN_W-1:0]  byte_length,
  input  logic              low_speed,
  input  logic              is_bulk,
  input  logic [SLOT_W-1:0] first_slot,
  input  logic              link_onward,
  // descriptor results
  output logic              strobe,
  output logic [SLOT_W-1:0] slot_index,
  output logic [31:0]       link_word,
  output logic [31:0]       status_word,
  output logic [31:0]       token_word,
  output logic [31:0]       buffer_word,
  output logic              following_toggle,
  output logic              error_flag,
  output logic              last_flag
);

  // The sequencer walks idle -> count -> check -> emit. Counting takes one packet size out of
  // the remaining length per cycle, so the piece count is known (and the 64-piece limit and
  // pool overrun checked) before the first descriptor transaction goes out. A rejected request
  // gives one error transaction and the sequencer drops back to idle.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  usbtd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the registers, the latched request, running slot, buffer and link
  // addresses, and the output registers; a new request can be accepted while the last
  // descriptor transaction of the previous one still sits on the outputs.
  usbtd_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .cmd              (cmd),
    .stat             (stat),
    .usb_address      (usb_address),
    .endpoint         (endpoint),
    .packet_kind      (packet_kind),
    .start_toggle     (start_toggle),
    .buffer_address   (buffer_address),
    .byte_length      (byte_length),
    .low_speed        (low_speed),
    .is_bulk          (is_bulk),
    .first_slot       (first_slot),
    .link_onward      (link_onward),
    .strobe           (strobe),
    .slot_index       (slot_index),
    .link_word        (link_word),
    .status_word      (status_word),
    .token_word       (token_word),
    .buffer_word      (buffer_word),
    .following_toggle (following_toggle),
    .error_flag       (error_flag),
    .last_flag        (last_flag)
  );

  // A reject transaction carries nothing but the error flag
  `UTD_ASSERT_IMP(a_err_clean, strobe && error_flag, !last_flag && token_word == 32'd0)
  // An accepted request always keeps the block busy for the next cycle
  `UTD_ASSERT_NXT(a_start_busy, start && !busy, busy)
  // Descriptors of one chain go out back to back
  `UTD_ASSERT_NXT(a_chain_dense, strobe && !error_flag && !last_flag, strobe)
  // The following toggle is the inverse of the toggle packed in the token
  `UTD_ASSERT_IMP(a_toggle_flip, strobe && !error_flag, following_toggle != token_word[19])

endmodule

// ----- rtl/core/usbtd_ctrl.sv -----
module usbtd_ctrl
  import usbtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COUNT = 4'b0010,
    S_CHECK = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        if (stat.early_bad) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.rem_gt_mp) begin
          if (stat.cnt_full) begin
            cmd.emit_err = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.count_step = 1'b1;
          end
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.slot_bad) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (stat.last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/usbtd_dp.sv -----
module usbtd_dp
  import usbtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [31:0]       wr_data,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [6:0]        usb_address,
  input  logic [3:0]        endpoint,
  input  logic [1:0]        packet_kind,
  input  logic              start_toggle,
  input  logic [31:0]       buffer_address,
  input  logic [LEN_W-1:0]  byte_length,
  input  logic              low_speed,
  input  logic              is_bulk,
  input  logic [SLOT_W-1:0] first_slot,
  input  logic              link_onward,
  output logic              strobe,
  output logic [SLOT_W-1:0] slot_index,
  output logic [31:0]       link_word,
  output logic [31:0]       status_word,
  output logic [31:0]       token_word,
  output logic [31:0]       buffer_word,
  output logic              following_toggle,
  output logic              error_flag,
  output logic              last_flag
);

  logic [31:0]       pool_base;
  logic [MP_W-1:0]   max_packet;

  logic [6:0]        addr;
  logic [3:0]        ep;
  logic [1:0]        kind;
  logic              tog;
  logic [31:0]       buf_start;
  logic [LEN_W-1:0]  len;
  logic              low;
  logic              bulk;
  logic [SLOT_W-1:0] slot;
  logic              onward;
  logic [MP_W-1:0]   mp;

  logic [LEN_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  idx;
  logic [SLOT_W-1:0] slot_cur;
  logic [31:0]       buf_cur;
  logic [31:0]       link_addr;

  logic [MP_W-1:0]   mp_eff;
  logic [END_W-1:0]  end_slot;
  logic [SLOT_W:0]   slot_inc;
  logic [10:0]       plen_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      max_packet <= MP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_POOL_BASE:  pool_base  <= wr_data;
        REG_MAX_PACKET: max_packet <= wr_data[MP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the packet size into 1..64
  always_comb begin
    if (max_packet == '0) begin
      mp_eff = 7'd1;
    end else if (max_packet > MP_MAX) begin
      mp_eff = MP_MAX;
    end else begin
      mp_eff = max_packet;
    end
  end

  assign end_slot = END_W'(slot) + END_W'(cnt) - END_W'(1) + END_W'(onward);
  assign slot_inc = {1'b0, slot} + (SLOT_W+1)'(1);

  assign stat.early_bad = (low & bulk) | (len > LEN_LIMIT) | (kind == KIND_BAD);
  assign stat.rem_gt_mp = (rem > LEN_W'(mp));
  assign stat.cnt_full  = (cnt == CNT_W'(MAX_PIECES));
  assign stat.slot_bad  = (end_slot >= END_W'(POOL_SLOTS));
  assign stat.last      = (idx == cnt);

  // Final piece carries the remainder; a null packet wraps to all ones
  assign plen_m1 = stat.last ? (rem[10:0] - 11'd1) : (11'(mp) - 11'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr      <= usb_address;
      ep        <= endpoint;
      kind      <= packet_kind;
      tog       <= start_toggle;
      buf_start <= buffer_address;
      len       <= byte_length;
      low       <= low_speed;
      bulk      <= is_bulk;
      slot      <= first_slot;
      onward    <= link_onward;
      mp        <= mp_eff;
      rem       <= byte_length;
      cnt       <= CNT_W'(1);
    end else if (cmd.count_step) begin
      rem <= rem - LEN_W'(mp);
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.emit_init) begin
      rem       <= len;
      idx       <= CNT_W'(1);
      slot_cur  <= slot;
      buf_cur   <= buf_start;
      link_addr <= pool_base + {17'd0, slot_inc, 5'd0};
    end else if (cmd.emit_step) begin
      rem       <= rem - LEN_W'(mp);
      idx       <= idx + CNT_W'(1);
      slot_cur  <= slot_cur + SLOT_W'(1);
      buf_cur   <= buf_cur + 32'(mp);
      link_addr <= link_addr + 32'd32;
      tog       <= ~tog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_step | cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      slot_index       <= '0;
      link_word        <= '0;
      status_word      <= '0;
      token_word       <= '0;
      buffer_word      <= '0;
      following_toggle <= 1'b0;
      error_flag       <= 1'b1;
      last_flag        <= 1'b0;
    end else if (cmd.emit_step) begin
      slot_index       <= slot_cur;
      link_word        <= (stat.last && !onward) ? LINK_END : (link_addr | LINK_DEPTH);
      status_word      <= low ? ST_LOW : ST_FULL;
      token_word       <= {plen_m1, 1'b0, tog, ep, addr, pid_of(kind)};
      buffer_word      <= buf_cur;
      following_toggle <= ~tog;
      error_flag       <= 1'b0;
      last_flag        <= stat.last;
    end
  end

endmodule
